// ===== hdl/slpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpe_pkg
// Shared types and constants for the status LED pattern engine.
// ----------------------------------------------------------------------------
package slpe_pkg;

    localparam int unsigned NOW_W     = 32;
    localparam int unsigned ARG_W     = 8;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned COLOR_W   = 3;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_STATUS    = 3'd1,
        CMD_NETWORK   = 3'd2,
        CMD_QUALITY   = 3'd3,
        CMD_FLASH     = 3'd4,
        CMD_PATTERN   = 3'd5,
        CMD_INDICATOR = 3'd6,
        CMD_MUTE      = 3'd7
    } cmd_t;

    typedef enum logic [COLOR_W-1:0] {
        COLOR_OFF     = 3'd0,
        COLOR_RED     = 3'd1,
        COLOR_GREEN   = 3'd2,
        COLOR_BLUE    = 3'd3,
        COLOR_CYAN    = 3'd4,
        COLOR_ORANGE  = 3'd5,
        COLOR_MAGENTA = 3'd6
    } color_t;

    // status modes
    localparam logic [2:0] MODE_READY      = 3'd1;
    localparam logic [2:0] MODE_CONNECTING = 3'd2;
    localparam logic [2:0] MODE_PORTAL     = 3'd3;
    localparam logic [2:0] MODE_FAULT      = 3'd4;

    // network states
    localparam logic [1:0] NET_CONNECTED = 2'd1;
    localparam logic [1:0] NET_AP        = 2'd2;
    localparam logic [1:0] NET_AP_CLIENT = 2'd3;

    // system patterns
    localparam logic [2:0] PAT_NONE      = 3'd0;
    localparam logic [2:0] PAT_UPDATING  = 3'd1;
    localparam logic [2:0] PAT_UPDATE_OK = 3'd2;
    localparam logic [2:0] PAT_UPD_FAIL  = 3'd3;
    localparam logic [2:0] PAT_RECOVERY  = 3'd4;

    // indicator modes
    localparam logic [1:0] IND_LOCATE = 2'd1;
    localparam logic [1:0] IND_MUTE   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RGB        = 1'd1;

    localparam logic [PCT_W-1:0]   PCT_MAX       = 7'd100;
    localparam logic [COLOR_W-1:0] COLOR_MAX     = 3'd6;
    localparam logic [NOW_W-1:0]   FLASH_MS      = 32'd50;
    localparam logic [NOW_W-1:0]   FAIL_HOLD_MS  = 32'd2500;
    localparam logic [NOW_W-1:0]   LOCATE_MS     = 32'd150;
    localparam logic [NOW_W-1:0]   BLINK_CONN_MS = 32'd500;
    localparam logic [NOW_W-1:0]   BLINK_PORT_MS = 32'd150;
    localparam logic [NOW_W-1:0]   BLINK_FLT_MS  = 32'd120;
    localparam logic [PCT_W-1:0]   Q_LOW         = 7'd25;
    localparam logic [PCT_W-1:0]   Q_MID         = 7'd50;

    // now % 2000 = {(now >> 4) % 125, now[3:0]}; the quotient by 125 uses
    // a reciprocal multiply, exact for 28-bit dividends.
    localparam int unsigned DIV_IN_W  = 28;
    localparam int unsigned RECIP_W   = 29;
    localparam int unsigned RECIP_SH  = 35;
    localparam int unsigned QUOT_W    = 22;
    localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;
    localparam logic [7:0]         DIV_125   = 8'd125;

    // phase windows over now % 2000
    function automatic logic early_200(input logic [10:0] r);
        early_200 = (r < 11'd200);
    endfunction

    function automatic logic early_1000(input logic [10:0] r);
        early_1000 = (r < 11'd200) || ((r >= 11'd1000) && (r < 11'd1200));
    endfunction

    function automatic logic early_400(input logic [10:0] r);
        early_400 = (r < 11'd200)
                 || ((r >= 11'd400)  && (r < 11'd600))
                 || ((r >= 11'd800)  && (r < 11'd1000))
                 || ((r >= 11'd1200) && (r < 11'd1400))
                 || ((r >= 11'd1600) && (r < 11'd1800));
    endfunction

endpackage
`default_nettype wire

// ===== hdl/status_led_pattern_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_led_pattern_engine_top
// Turns timestamped commands into network / activity LED color pairs.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle unless the pipeline stalls. A tick
// request yields one color pair on the m_ side; every other command only
// updates state and yields nothing. The block is a three-register pipeline:
// input register, a register after the reciprocal multiply that reduces
// now_ms modulo 2000, and the result register; all LED state is read and
// written in a single cycle in the stage before the result register, so
// back-to-back requests see each other's effects in order. The m_ side may
// stall; the pipeline then holds a tick until its pair can be stored, while
// other commands keep going. Register writes are meant for an idle block.
module status_led_pattern_engine_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [slpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slpe_pkg::PCT_W-1:0]     cfg_wdata,
    // requests
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [slpe_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] now_ms, [39:32] argument
    input  wire logic [slpe_pkg::CMD_W-1:0]     s_tuser,   // [2:0] command
    // color pairs
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [slpe_pkg::M_TDATA_W-1:0]      m_tdata    // [2:0] network_color,
                                                           // [5:3] activity_color,
                                                           // [12:6] brightness_out
);

    localparam int unsigned NW = slpe_pkg::NOW_W;
    localparam int unsigned CW = slpe_pkg::COLOR_W;
    localparam int unsigned PW = slpe_pkg::PCT_W;
    localparam int unsigned DW = slpe_pkg::DIV_IN_W;
    localparam int unsigned QW = slpe_pkg::QUOT_W;
    localparam int unsigned MW = slpe_pkg::DIV_IN_W + slpe_pkg::RECIP_W;
    localparam int unsigned S_ARG_HI = NW + slpe_pkg::ARG_W - 1;

    // ---------------- configuration ----------------
    logic [PW-1:0] brightness_reg;
    logic          rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= slpe_pkg::PCT_MAX;
            rgb_reg        <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                slpe_pkg::REG_BRIGHTNESS: begin
                    brightness_reg <= (cfg_wdata > slpe_pkg::PCT_MAX) ? slpe_pkg::PCT_MAX
                                                                      : cfg_wdata;
                end
                slpe_pkg::REG_RGB: begin
                    rgb_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic                        p1_valid_reg;
    slpe_pkg::cmd_t              p1_cmd_reg;
    logic [NW-1:0]               p1_now_reg;
    logic [slpe_pkg::ARG_W-1:0]  p1_arg_reg;

    logic                        p2_valid_reg;
    slpe_pkg::cmd_t              p2_cmd_reg;
    logic [NW-1:0]               p2_now_reg;
    logic [slpe_pkg::ARG_W-1:0]  p2_arg_reg;
    logic [QW-1:0]               p2_quot_reg;

    logic                        m_valid_reg;
    logic [slpe_pkg::M_TDATA_W-1:0] m_data_reg;

    logic p2_is_tick;
    logic p2_fire;
    logic p1_adv;
    logic s_fire;

    assign p2_is_tick = (p2_cmd_reg == slpe_pkg::CMD_TICK);
    assign p2_fire    = p2_valid_reg && (!p2_is_tick || !m_valid_reg || m_tready);
    assign p1_adv     = !p2_valid_reg || p2_fire;
    assign s_tready   = !p1_valid_reg || p1_adv;
    assign s_fire     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_cmd_reg <= slpe_pkg::cmd_t'(s_tuser);
            p1_now_reg <= s_tdata[NW-1:0];
            p1_arg_reg <= s_tdata[S_ARG_HI:NW];
        end
    end

    // quotient of now[31:4] by 125
    logic [MW-1:0] recip_prod;
    assign recip_prod = MW'(p1_now_reg[NW-1:4]) * MW'(slpe_pkg::RECIP_125);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && p1_valid_reg) begin
            p2_cmd_reg  <= p1_cmd_reg;
            p2_now_reg  <= p1_now_reg;
            p2_arg_reg  <= p1_arg_reg;
            p2_quot_reg <= recip_prod[slpe_pkg::RECIP_SH +: QW];
        end
    end

    // ---------------- phase windows ----------------
    logic [DW-1:0] quot_x125;
    logic [DW-1:0] rem_raw;
    logic [7:0]    rem_125;
    logic [10:0]   r2000;
    logic          early2000;
    logic          early1000;
    logic          early400;

    assign quot_x125 = (DW'(p2_quot_reg) << 7) - (DW'(p2_quot_reg) << 2) + DW'(p2_quot_reg);
    assign rem_raw   = p2_now_reg[NW-1:4] - quot_x125;
    assign rem_125   = (rem_raw[7:0] >= slpe_pkg::DIV_125) ? rem_raw[7:0] - slpe_pkg::DIV_125
                                                            : rem_raw[7:0];
    assign r2000     = {rem_125[6:0], p2_now_reg[3:0]};
    assign early2000 = slpe_pkg::early_200(r2000);
    assign early1000 = slpe_pkg::early_1000(r2000);
    assign early400  = slpe_pkg::early_400(r2000);

    // ---------------- LED state ----------------
    logic [2:0]    status_mode_reg;
    logic [1:0]    net_state_reg;
    logic [PW-1:0] quality_reg;
    logic [NW-1:0] blink_time_reg;
    logic          blink_on_reg;
    logic [NW-1:0] flash_end_reg;
    logic [CW-1:0] flash_color_reg;
    logic [2:0]    pattern_reg;
    logic [NW-1:0] pattern_end_reg;
    logic          pattern_exp_reg;
    logic [1:0]    ind_mode_reg;
    logic          muted_reg;
    logic [NW-1:0] locate_time_reg;
    logic          locate_on_reg;

    logic [2:0]    status_mode_next;
    logic [1:0]    net_state_next;
    logic [PW-1:0] quality_next;
    logic [NW-1:0] blink_time_next;
    logic          blink_on_next;
    logic [NW-1:0] flash_end_next;
    logic [CW-1:0] flash_color_next;
    logic [2:0]    pattern_next;
    logic [NW-1:0] pattern_end_next;
    logic          pattern_exp_next;
    logic [1:0]    ind_mode_next;
    logic          muted_next;
    logic [NW-1:0] locate_time_next;
    logic          locate_on_next;

    slpe_pkg::color_t net_color;
    slpe_pkg::color_t act_color;
    slpe_pkg::color_t ready_color;
    slpe_pkg::color_t pat_a;
    slpe_pkg::color_t pat_b;

    logic [NW-1:0] now;
    logic [NW-1:0] pat_diff;
    logic          pat_active;
    logic          pat_expired;
    logic          blink_mode;
    logic [NW-1:0] blink_period;
    slpe_pkg::color_t blink_color;
    logic [2:0]    pat_arg;

    assign now        = p2_now_reg;
    assign pat_diff   = now - pattern_end_reg;
    assign pat_active = (pattern_reg != slpe_pkg::PAT_NONE);
    assign pat_expired = pattern_exp_reg && !pat_diff[NW-1];
    assign pat_arg    = (p2_arg_reg > 8'(slpe_pkg::PAT_RECOVERY)) ? slpe_pkg::PAT_NONE
                                                                  : p2_arg_reg[2:0];

    always_comb begin
        case (net_state_reg)
            slpe_pkg::NET_CONNECTED: begin
                if (quality_reg < slpe_pkg::Q_LOW) begin
                    if (rgb_reg) begin
                        ready_color = early2000 ? slpe_pkg::COLOR_RED : slpe_pkg::COLOR_GREEN;
                    end else begin
                        ready_color = early2000 ? slpe_pkg::COLOR_GREEN : slpe_pkg::COLOR_OFF;
                    end
                end else if (quality_reg < slpe_pkg::Q_MID) begin
                    if (rgb_reg) begin
                        ready_color = early2000 ? slpe_pkg::COLOR_ORANGE
                                                : slpe_pkg::COLOR_GREEN;
                    end else begin
                        ready_color = early2000 ? slpe_pkg::COLOR_OFF : slpe_pkg::COLOR_GREEN;
                    end
                end else begin
                    ready_color = slpe_pkg::COLOR_GREEN;
                end
            end
            slpe_pkg::NET_AP_CLIENT: begin
                ready_color = rgb_reg ? slpe_pkg::COLOR_BLUE : slpe_pkg::COLOR_GREEN;
            end
            slpe_pkg::NET_AP: begin
                ready_color = early1000 ? slpe_pkg::COLOR_BLUE : slpe_pkg::COLOR_OFF;
            end
            default: begin
                ready_color = slpe_pkg::COLOR_RED;
            end
        endcase
    end

    always_comb begin
        blink_mode   = 1'b1;
        blink_period = slpe_pkg::BLINK_CONN_MS;
        blink_color  = slpe_pkg::COLOR_RED;
        case (status_mode_reg)
            slpe_pkg::MODE_CONNECTING: begin
                blink_period = slpe_pkg::BLINK_CONN_MS;
            end
            slpe_pkg::MODE_PORTAL: begin
                blink_period = slpe_pkg::BLINK_PORT_MS;
                blink_color  = slpe_pkg::COLOR_ORANGE;
            end
            slpe_pkg::MODE_FAULT: begin
                blink_period = slpe_pkg::BLINK_FLT_MS;
            end
            default: begin
                blink_mode = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (pattern_reg)
            slpe_pkg::PAT_UPDATING: begin
                pat_a = slpe_pkg::COLOR_ORANGE;
                pat_b = slpe_pkg::COLOR_OFF;
            end
            slpe_pkg::PAT_UPD_FAIL: begin
                pat_a = slpe_pkg::COLOR_RED;
                pat_b = slpe_pkg::COLOR_OFF;
            end
            slpe_pkg::PAT_UPDATE_OK: begin
                pat_a = slpe_pkg::COLOR_GREEN;
                pat_b = slpe_pkg::COLOR_GREEN;
            end
            default: begin
                pat_a = slpe_pkg::COLOR_BLUE;
                pat_b = slpe_pkg::COLOR_RED;
            end
        endcase
    end

    always_comb begin
        status_mode_next = status_mode_reg;
        net_state_next   = net_state_reg;
        quality_next     = quality_reg;
        blink_time_next  = blink_time_reg;
        blink_on_next    = blink_on_reg;
        flash_end_next   = flash_end_reg;
        flash_color_next = flash_color_reg;
        pattern_next     = pattern_reg;
        pattern_end_next = pattern_end_reg;
        pattern_exp_next = pattern_exp_reg;
        ind_mode_next    = ind_mode_reg;
        muted_next       = muted_reg;
        locate_time_next = locate_time_reg;
        locate_on_next   = locate_on_reg;
        net_color        = slpe_pkg::COLOR_OFF;
        act_color        = slpe_pkg::COLOR_OFF;

        case (p2_cmd_reg)
            slpe_pkg::CMD_TICK: begin
                if (pat_active && pat_expired) begin
                    pattern_next     = slpe_pkg::PAT_NONE;
                    pattern_end_next = '0;
                    pattern_exp_next = 1'b0;
                end
                if (pat_active && !pat_expired) begin
                    net_color = early400 ? pat_a : pat_b;
                    act_color = early400 ? pat_b : pat_a;
                end else if (muted_reg || ind_mode_reg == slpe_pkg::IND_MUTE) begin
                    net_color = slpe_pkg::COLOR_OFF;
                    act_color = slpe_pkg::COLOR_OFF;
                end else if (ind_mode_reg == slpe_pkg::IND_LOCATE) begin
                    if ((now - locate_time_reg) >= slpe_pkg::LOCATE_MS) begin
                        locate_time_next = now;
                        locate_on_next   = !locate_on_reg;
                    end
                    net_color = locate_on_next ? slpe_pkg::COLOR_MAGENTA : slpe_pkg::COLOR_OFF;
                    act_color = net_color;
                end else begin
                    if (status_mode_reg == slpe_pkg::MODE_READY) begin
                        net_color = ready_color;
                    end else if (blink_mode) begin
                        if ((now - blink_time_reg) >= blink_period) begin
                            blink_time_next = now;
                            blink_on_next   = !blink_on_reg;
                        end
                        net_color = blink_on_next ? blink_color : slpe_pkg::COLOR_OFF;
                    end
                    act_color = (now < flash_end_reg) ? slpe_pkg::color_t'(flash_color_reg)
                                                      : slpe_pkg::COLOR_OFF;
                end
            end
            slpe_pkg::CMD_STATUS: begin
                status_mode_next = p2_arg_reg[2:0];
            end
            slpe_pkg::CMD_NETWORK: begin
                net_state_next = p2_arg_reg[1:0];
            end
            slpe_pkg::CMD_QUALITY: begin
                quality_next = (p2_arg_reg > 8'(slpe_pkg::PCT_MAX)) ? slpe_pkg::PCT_MAX
                                                                    : p2_arg_reg[PW-1:0];
            end
            slpe_pkg::CMD_FLASH: begin
                flash_color_next = (p2_arg_reg > 8'(slpe_pkg::COLOR_MAX)) ? slpe_pkg::COLOR_OFF
                                                                          : p2_arg_reg[CW-1:0];
                flash_end_next   = now + slpe_pkg::FLASH_MS;
            end
            slpe_pkg::CMD_PATTERN: begin
                pattern_next = pat_arg;
                if (pat_arg == slpe_pkg::PAT_UPD_FAIL) begin
                    pattern_end_next = now + slpe_pkg::FAIL_HOLD_MS;
                    pattern_exp_next = 1'b1;
                end else begin
                    pattern_end_next = '0;
                    pattern_exp_next = 1'b0;
                end
            end
            slpe_pkg::CMD_INDICATOR: begin
                ind_mode_next = p2_arg_reg[1:0];
                // entering locate restarts its phase, dark first
                if (p2_arg_reg[1:0] == slpe_pkg::IND_LOCATE) begin
                    locate_time_next = now;
                    locate_on_next   = 1'b0;
                end
            end
            default: begin
                muted_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_mode_reg <= '0;
            net_state_reg   <= '0;
            quality_reg     <= slpe_pkg::PCT_MAX;
            blink_time_reg  <= '0;
            blink_on_reg    <= 1'b0;
            flash_end_reg   <= '0;
            flash_color_reg <= slpe_pkg::COLOR_OFF;
            pattern_reg     <= slpe_pkg::PAT_NONE;
            pattern_end_reg <= '0;
            pattern_exp_reg <= 1'b0;
            ind_mode_reg    <= '0;
            muted_reg       <= 1'b0;
            locate_time_reg <= '0;
            locate_on_reg   <= 1'b0;
        end else if (p2_fire) begin
            status_mode_reg <= status_mode_next;
            net_state_reg   <= net_state_next;
            quality_reg     <= quality_next;
            blink_time_reg  <= blink_time_next;
            blink_on_reg    <= blink_on_next;
            flash_end_reg   <= flash_end_next;
            flash_color_reg <= flash_color_next;
            pattern_reg     <= pattern_next;
            pattern_end_reg <= pattern_end_next;
            pattern_exp_reg <= pattern_exp_next;
            ind_mode_reg    <= ind_mode_next;
            muted_reg       <= muted_next;
            locate_time_reg <= locate_time_next;
            locate_on_reg   <= locate_on_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p2_fire && p2_is_tick) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_fire && p2_is_tick) begin
            m_data_reg <= {3'b000, brightness_reg, act_color, net_color};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    a_expiry_only_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        pattern_exp_reg |-> (pattern_reg == slpe_pkg::PAT_UPD_FAIL))
        else $error("pattern expiry armed for a pattern that does not expire");

    a_mute_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        muted_reg |=> muted_reg)
        else $error("mute cleared without reset");

    a_tick_gives_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_fire && p2_is_tick) |=> m_valid_reg)
        else $error("tick request produced no color pair");

    a_cmd_no_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_fire && !p2_is_tick && !m_valid_reg) |=> !m_valid_reg)
        else $error("non-tick request produced a color pair");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (brightness_reg <= slpe_pkg::PCT_MAX) && (quality_reg <= slpe_pkg::PCT_MAX))
        else $error("percent register above range");

endmodule
`default_nettype wire
